>>> rtl/gwkn_pkg.sv
// Package for the grid window k-nearest probe selector.
// Holds opcodes, status codes, register indexes and table sizes; no dependencies.
package gwkn_pkg;

    localparam int MAX_PROBES = 64;
    localparam int MAX_SELECT = 8;

    localparam int CELL_W   = 23;
    localparam int ACT_W    = 4;
    localparam int RAD_W    = 8;
    localparam int STATUS_W = 3;
    localparam int HANDLE_W = 6;

    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_OVERWRITE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_QUERY     = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_WRITTEN = 3'd0,
        ST_HIT     = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_BAD     = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_CELL_SIZE = 2'd0,
        REG_MAX_ACTIVE = 2'd1,
        REG_RADIUS    = 2'd2
    } reg_index_t;

endpackage

>>> rtl/grid_window_k_nearest_box_select.sv
// Top level of the grid window k-nearest probe selector: probe memories,
// sequencer, shared square-accumulate unit and sorted best list. Uses gwkn_pkg.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  in        | in_valid/in_stall  | opcode, probe_index, box_*, point_*
//  out       | out_valid/out_stall| status, probe_handle, last
//  cfg       | cfg_we             | cfg_index, cfg_data
//
// A write goes through S_WRITE, then S_OUT; a clear or a rejected write goes
// straight to S_OUT. A query divides the point's x and z into its cell, then
// per stored probe reads it, passes its four box cells through the shared
// divider and its axes through the shared squarer and inserts it, then emits
// one result per cycle while out_stall is low. Reset clears the probe count
// and restores config defaults; probe memories are not cleared. out_stall
// holds the sequencer; the input stalls while a result waits.
module grid_window_k_nearest_box_select
    import gwkn_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [HANDLE_W-1:0]           probe_index,
    input  logic signed [COORD_WIDTH-1:0] box_a_x,
    input  logic signed [COORD_WIDTH-1:0] box_a_y,
    input  logic signed [COORD_WIDTH-1:0] box_a_z,
    input  logic signed [COORD_WIDTH-1:0] box_b_x,
    input  logic signed [COORD_WIDTH-1:0] box_b_y,
    input  logic signed [COORD_WIDTH-1:0] box_b_z,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [STATUS_W-1:0]           status,
    output logic [HANDLE_W-1:0]           probe_handle,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [CELL_W-1:0]             cfg_data
);

    localparam int W     = COORD_WIDTH;
    localparam int IDX_W = $clog2(MAX_PROBES);
    localparam int TOT_W = $clog2(MAX_PROBES + 1);
    localparam int SEL_W = $clog2(MAX_SELECT);
    localparam int CNT_W = $clog2(MAX_SELECT + 1);
    localparam int D_W   = 2 * W + 3;
    localparam int Q_W   = W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_QDIV, S_QWAIT, S_READ, S_BDIV, S_BWAIT,
        S_SQ, S_INS, S_EMIT, S_OUT
    } state_t;

    typedef struct packed {
        logic signed [W-1:0] lx, ly, lz, hx, hy, hz, cx, cy, cz;
    } probe_t;

    probe_t mem [MAX_PROBES];
    probe_t rd_reg;

    logic [CELL_W-1:0] cell_size_reg;
    logic [ACT_W-1:0]  max_active_reg;
    logic [RAD_W-1:0]  radius_reg;

    state_t state_reg;
    logic [TOT_W-1:0] total_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] wr_idx_reg;
    probe_t           wr_reg;
    logic             wr_en_reg;
    logic signed [W-1:0] px_reg, py_reg, pz_reg;
    logic signed [Q_W+1:0] wlx_reg, whx_reg, wlz_reg, whz_reg;
    logic [1:0]       bsel_reg;
    logic signed [Q_W-1:0] blx_reg, blz_reg;
    logic             qsel_reg;
    logic [2:0]       sq_reg;
    logic [D_W-1:0]   db_reg, dc_reg;
    logic [CNT_W-1:0] count_reg, limit_reg, ptr_reg;
    logic [IDX_W-1:0] best_h [MAX_SELECT];
    logic [D_W-1:0]   best_b [MAX_SELECT];
    logic [D_W-1:0]   best_c [MAX_SELECT];

    logic                 out_valid_reg, last_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [HANDLE_W-1:0]  handle_reg;

    logic                  div_start;
    logic                  div_busy;
    logic signed [W-1:0]   div_num;
    logic signed [Q_W-1:0] div_q;
    logic signed [W:0]     sq_diff;
    logic [W:0]            sq_abs;
    logic [2*W+1:0]        sq_prod;
    logic [SEL_W:0]        lim_sel;
    logic                  better [MAX_SELECT];
    logic                  qpos;
    logic signed [Q_W+1:0] rad_s;
    logic                  load_out;
    logic signed [W-1:0]   sa, sb;

    gwkn_floor_div #(.NUM_W(W), .DEN_W(CELL_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cell_size_reg),
        .busy  (div_busy),
        .quo   (div_q)
    );

    assign lim_sel = (max_active_reg > ACT_W'(MAX_SELECT)) ? (SEL_W+1)'(MAX_SELECT)
                                                          : (SEL_W+1)'(max_active_reg);

    assign load_out = ((state_reg == S_EMIT) || (state_reg == S_OUT))
                      && (!out_valid_reg || !out_stall);

    always_comb
    begin
        div_start = (state_reg == S_QDIV) || (state_reg == S_BDIV);
        div_num   = px_reg;
        if (state_reg == S_QDIV)
            div_num = qsel_reg ? pz_reg : px_reg;
        else
            unique case (bsel_reg)
                2'd0: div_num = rd_reg.lx;
                2'd1: div_num = rd_reg.hx;
                2'd2: div_num = rd_reg.lz;
                2'd3: div_num = rd_reg.hz;
                default: div_num = rd_reg.lx;
            endcase
    end

    // one shared squarer: steps 0..2 box axes, 3..5 centre axes
    always_comb
    begin
        sa = px_reg;
        sb = rd_reg.cx;
        case (sq_reg)
            3'd0: begin sa = px_reg; sb = (px_reg < rd_reg.lx) ? rd_reg.lx
                     : (px_reg > rd_reg.hx) ? rd_reg.hx : px_reg; end
            3'd1: begin sa = py_reg; sb = (py_reg < rd_reg.ly) ? rd_reg.ly
                     : (py_reg > rd_reg.hy) ? rd_reg.hy : py_reg; end
            3'd2: begin sa = pz_reg; sb = (pz_reg < rd_reg.lz) ? rd_reg.lz
                     : (pz_reg > rd_reg.hz) ? rd_reg.hz : pz_reg; end
            3'd3: begin sa = px_reg; sb = rd_reg.cx; end
            3'd4: begin sa = py_reg; sb = rd_reg.cy; end
            3'd5: begin sa = pz_reg; sb = rd_reg.cz; end
            default: begin sa = px_reg; sb = px_reg; end
        endcase
        sq_diff = (W+1)'(sa) - (W+1)'(sb);
        sq_abs  = sq_diff[W] ? (W+1)'(-sq_diff) : (W+1)'(sq_diff);
        sq_prod = sq_abs * sq_abs;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_SELECT; k++)
            better[k] = (db_reg < best_b[k]) || (db_reg == best_b[k] && dc_reg < best_c[k]);
    end

    assign rad_s = (Q_W+2)'(radius_reg);
    assign qpos = (whx_reg >= -rad_s) && (wlx_reg <= rad_s) &&
                  (whz_reg >= -rad_s) && (wlz_reg <= rad_s);

    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
            mem[wr_idx_reg] <= wr_reg;
        rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            cell_size_reg  <= CELL_W'(8192);
            max_active_reg <= ACT_W'(8);
            radius_reg     <= RAD_W'(1);
            out_valid_reg  <= 1'b0;
            wr_en_reg      <= 1'b0;
            idx_reg        <= '0;
            count_reg      <= '0;
            ptr_reg        <= '0;
        end
        else
        begin
            wr_en_reg <= (state_reg == S_WRITE);
            if (cfg_we)
                unique case (cfg_index)
                    REG_CELL_SIZE:  cell_size_reg  <= cfg_data;
                    REG_MAX_ACTIVE: max_active_reg <= cfg_data[ACT_W-1:0];
                    REG_RADIUS:     radius_reg     <= cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && !out_valid_reg)
                    begin
                        px_reg <= point_x;
                        py_reg <= point_y;
                        pz_reg <= point_z;
                        wr_reg.lx <= (box_a_x < box_b_x) ? box_a_x : box_b_x;
                        wr_reg.hx <= (box_a_x < box_b_x) ? box_b_x : box_a_x;
                        wr_reg.ly <= (box_a_y < box_b_y) ? box_a_y : box_b_y;
                        wr_reg.hy <= (box_a_y < box_b_y) ? box_b_y : box_a_y;
                        wr_reg.lz <= (box_a_z < box_b_z) ? box_a_z : box_b_z;
                        wr_reg.hz <= (box_a_z < box_b_z) ? box_b_z : box_a_z;
                        wr_reg.cx <= point_x;
                        wr_reg.cy <= point_y;
                        wr_reg.cz <= point_z;
                        last_reg   <= 1'b1;
                        unique case (opcode)
                            OP_APPEND:
                                if (total_reg == TOT_W'(MAX_PROBES))
                                begin
                                    status_reg <= ST_FULL;
                                    handle_reg <= '0;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    status_reg <= ST_WRITTEN;
                                    wr_idx_reg <= total_reg[IDX_W-1:0];
                                    handle_reg <= HANDLE_W'(total_reg);
                                    total_reg  <= total_reg + 1'b1;
                                    state_reg  <= S_WRITE;
                                end
                            OP_OVERWRITE:
                                if (TOT_W'(probe_index) >= total_reg)
                                begin
                                    status_reg <= ST_BAD;
                                    handle_reg <= '0;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    status_reg <= ST_WRITTEN;
                                    wr_idx_reg <= IDX_W'(probe_index);
                                    handle_reg <= probe_index;
                                    state_reg  <= S_WRITE;
                                end
                            OP_CLEAR:
                            begin
                                status_reg <= ST_WRITTEN;
                                handle_reg <= '0;
                                total_reg  <= '0;
                                state_reg  <= S_OUT;
                            end
                            OP_QUERY:
                            begin
                                if (lim_sel == '0 || total_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    handle_reg <= '0;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    limit_reg <= CNT_W'(lim_sel);
                                    count_reg <= '0;
                                    idx_reg   <= '0;
                                    qsel_reg  <= 1'b0;
                                    state_reg <= S_QDIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                S_WRITE:
                    state_reg <= S_OUT;
                S_QDIV:
                    state_reg <= S_QWAIT;
                S_QWAIT:
                    if (!div_busy)
                    begin
                        if (!qsel_reg)
                        begin
                            blx_reg   <= div_q;
                            qsel_reg  <= 1'b1;
                            state_reg <= S_QDIV;
                        end
                        else
                        begin
                            blz_reg   <= div_q;
                            state_reg <= S_READ;
                        end
                    end
                S_READ:
                begin
                    bsel_reg  <= 2'd0;
                    state_reg <= S_BDIV;
                end
                S_BDIV:
                    state_reg <= S_BWAIT;
                S_BWAIT:
                    if (!div_busy)
                    begin
                        // store cell offsets relative to the query cell
                        unique case (bsel_reg)
                            2'd0: wlx_reg <= (Q_W+2)'(div_q) - (Q_W+2)'(blx_reg);
                            2'd1: whx_reg <= (Q_W+2)'(div_q) - (Q_W+2)'(blx_reg);
                            2'd2: wlz_reg <= (Q_W+2)'(div_q) - (Q_W+2)'(blz_reg);
                            2'd3: whz_reg <= (Q_W+2)'(div_q) - (Q_W+2)'(blz_reg);
                            default: ;
                        endcase
                        bsel_reg <= bsel_reg + 1'b1;
                        if (bsel_reg == 2'd3)
                        begin
                            sq_reg    <= '0;
                            db_reg    <= '0;
                            dc_reg    <= '0;
                            state_reg <= S_SQ;
                        end
                        else
                            state_reg <= S_BDIV;
                    end
                S_SQ:
                begin
                    if (sq_reg < 3'd3)
                        db_reg <= db_reg + D_W'(sq_prod);
                    else
                        dc_reg <= dc_reg + D_W'(sq_prod);
                    sq_reg <= sq_reg + 1'b1;
                    if (sq_reg == 3'd5)
                        state_reg <= S_INS;
                end
                S_INS:
                begin
                    if (qpos)
                    begin
                        for (int k = MAX_SELECT - 1; k >= 0; k--)
                        begin
                            if (CNT_W'(k) < limit_reg)
                            begin
                                if (k > 0 && (CNT_W'(k) > count_reg || better[k-1])
                                    && CNT_W'(k-1) < count_reg && better[k-1])
                                begin
                                    best_h[k] <= best_h[k-1];
                                    best_b[k] <= best_b[k-1];
                                    best_c[k] <= best_c[k-1];
                                end
                                else if ((CNT_W'(k) >= count_reg || better[k])
                                         && (k == 0 || CNT_W'(k-1) >= count_reg
                                             || !better[k-1]))
                                begin
                                    best_h[k] <= idx_reg;
                                    best_b[k] <= db_reg;
                                    best_c[k] <= dc_reg;
                                end
                            end
                        end
                        if (count_reg < limit_reg)
                            count_reg <= count_reg + 1'b1;
                    end
                    if (TOT_W'(idx_reg) + 1'b1 >= total_reg)
                    begin
                        ptr_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_EMIT:
                    if (load_out)
                    begin
                        if (count_reg == '0)
                        begin
                            status_reg <= ST_EMPTY;
                            handle_reg <= '0;
                            last_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            status_reg <= ST_HIT;
                            handle_reg <= HANDLE_W'(best_h[ptr_reg[SEL_W-1:0]]);
                            last_reg   <= (ptr_reg + 1'b1 == count_reg);
                            ptr_reg    <= ptr_reg + 1'b1;
                            if (ptr_reg + 1'b1 == count_reg)
                                state_reg <= S_IDLE;
                        end
                    end
                S_OUT:
                    if (load_out)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign probe_handle = handle_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> count_reg <= CNT_W'(MAX_SELECT))
        else $error("best list overflow");
    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOT_W'(MAX_PROBES))
        else $error("probe count overflow");
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input open while busy");
    a_hit_handle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_HIT |-> TOT_W'(probe_handle) < total_reg)
        else $error("selected handle out of range");
`endif

endmodule

>>> rtl/gwkn_floor_div.sv
// Iterative signed floor divider, one quotient bit per cycle.
// Depends on gwkn_pkg.
module gwkn_floor_div
    import gwkn_pkg::*;
#(
    parameter int NUM_W = 24,
    parameter int DEN_W = 23
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    busy,
    output logic signed [NUM_W:0]   quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] mag_reg, mag_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;
    logic [NUM_W:0]   qmag;
    logic             rem_nz;

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DEN_W-1:0], mag_reg[NUM_W-1]};
        if (start)
        begin
            neg_next  = num[NUM_W-1];
            mag_next  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_next  = '0;
            den_next  = (den == '0) ? DEN_W'(1) : den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                mag_next = {mag_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                mag_next = {mag_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rem_nz = (rem_reg != '0);
    assign qmag   = {1'b0, mag_reg};
    assign busy   = busy_reg;
    assign quo    = neg_reg ? -$signed(qmag + (NUM_W+1)'(rem_nz)) : $signed(qmag);

`ifndef NO_ASSERTIONS
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !$past(busy_reg) || $past(cnt_reg) == CNT_W'(1) || $past(start))
        else $error("divider stopped early");
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider count underflow");
`endif

endmodule
